// File: hdl/pre_pkg.sv
// Shared types and constants for the pairwise repulsion energy block.
// Used by pre_mem, pre_term and pairwise_repulsion_energy; depends on nothing.
package pre_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int VADDR_W = $clog2(MAX_VERTICES);
  localparam int COUNT_W = VADDR_W + 1;
  localparam int POS_W = 24;
  localparam int ENTRY_W = 2 * POS_W;
  localparam int DIFF_W = POS_W + 1;
  localparam int SQR_W = 2 * DIFF_W;
  localparam int D2_W = SQR_W + 1;
  localparam int QUO_W = 30;
  localparam int TERM_W = 39;
  localparam int ENERGY_W = 62;
  localparam int ACC_W = 64;

  localparam logic [D2_W-1:0] DIST_FLOOR = D2_W'(429497);
  localparam logic [TERM_W-1:0] PENALTY = TERM_W'(64'd327680000000);
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [COUNT_W-1:0] VCOUNT_MAX = COUNT_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FULL   = 2'd1,
    CMD_DELTA  = 2'd2,
    CMD_COMMIT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               cur_we;
    logic               prev_we;
    logic               mark_we;
    logic [VADDR_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               mark_wdata;
    logic [VADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
  } term_req_t;

endpackage

// File: hdl/pairwise_repulsion_energy.sv
// Top level of the pairwise repulsion energy block: command sequencer and
// energy accumulators. Uses pre_pkg, pre_mem and pre_term.
//
// Usage: an item is taken at a clock edge with start high and busy low.
// A load (command 0) writes one vertex slot in that edge and leaves busy low.
// A commit (command 3) copies all 256 current slots to the previous store,
// with one read state and one write state a slot, and gives no result.
// A full command (1) walks every pair i < j below the vertex count; a delta
// command (2) first marks moved vertices, then walks each moved row against
// all other columns, skipping moved columns below it. A pair term goes
// through the shared term unit from request to result (four setup stages and
// the 49-step reciprocal divider, which is skipped when the penalty applies),
// and each pair adds the column read and latch states; a delta pair needs two
// terms, one on the current and one on the previous positions.
// The result beat appears with done high for
// exactly one cycle and must be taken then; the receiver cannot stall.
// The vertex count is written through cfg_valid/cfg_ready/cfg_data while idle.
// Synchronous reset clears the stored energy, the vertex count and the
// sequencer; the position stores and moved marks hold no value until written.
module pairwise_repulsion_energy (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pre_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [pre_pkg::VADDR_W-1:0]   vertex_index,
  input  logic signed [pre_pkg::POS_W-1:0] pos_x,
  input  logic signed [pre_pkg::POS_W-1:0] pos_y,
  output logic                          done,
  output logic [pre_pkg::ENERGY_W-1:0]  total_energy,
  output logic signed [pre_pkg::ENERGY_W:0] energy_change,
  output logic [pre_pkg::COUNT_W-1:0]   moved_vertices
);
  import pre_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_MARK_RD  = 11'b00000000010,
    S_MARK_CMP = 11'b00000000100,
    S_ROW_RD   = 11'b00000001000,
    S_ROW_LAT  = 11'b00000010000,
    S_COL_RD   = 11'b00000100000,
    S_COL_LAT  = 11'b00001000000,
    S_TERM     = 11'b00010000000,
    S_COPY_RD  = 11'b00100000000,
    S_COPY_WR  = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t state;
  logic [COUNT_W-1:0] num_vertices, n, i, j, moved_cnt;
  logic delta_mode, phase;
  logic [ENTRY_W-1:0] a_cur, a_prev, b_prev;
  logic [TERM_W-1:0] t_hold;
  logic [ENERGY_W-1:0] acc, energy;
  logic signed [ACC_W-1:0] dsum;
  logic signed [ACC_W:0] e_sum;
  logic [ENERGY_W:0] acc_sum;
  logic [ENTRY_W-1:0] cur_rd, prev_rd;
  logic mark_rd, term_done, accept, skip, moved;
  logic [TERM_W-1:0] term;
  mem_req_t mreq;
  term_req_t treq;
  cmd_t cmd;

  assign cmd = cmd_t'(command);
  assign busy = (state != S_IDLE);
  assign cfg_ready = ~busy & ~start;
  assign accept = start & ~busy;
  assign acc_sum = {1'b0, acc} + (ENERGY_W + 1)'(term);
  assign e_sum = $signed({3'b000, energy}) + $signed({dsum[ACC_W-1], dsum});
  assign skip = delta_mode & ((j == i) | (mark_rd & (j < i)));
  assign moved = (cur_rd != prev_rd);

  always_comb begin
    mreq = '0;
    mreq.raddr = i[VADDR_W-1:0];
    mreq.waddr = i[VADDR_W-1:0];
    mreq.wdata = cur_rd;
    mreq.mark_wdata = moved;
    unique case (state)
      S_IDLE: begin
        mreq.cur_we = accept & (cmd == CMD_LOAD);
        mreq.waddr = vertex_index;
        mreq.wdata = {pos_x, pos_y};
      end
      S_COL_RD: mreq.raddr = j[VADDR_W-1:0];
      S_MARK_CMP: mreq.mark_we = 1'b1;
      S_COPY_WR: mreq.prev_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    treq = '0;
    if (state == S_COL_LAT && !skip) begin
      treq.start = 1'b1;
      {treq.ax, treq.ay} = a_cur;
      {treq.bx, treq.by} = cur_rd;
    end else if (state == S_TERM && term_done && !phase && delta_mode) begin
      treq.start = 1'b1;
      {treq.ax, treq.ay} = a_prev;
      {treq.bx, treq.by} = b_prev;
    end
  end

  pre_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .cur_rd  (cur_rd),
    .prev_rd (prev_rd),
    .mark_rd (mark_rd)
  );

  pre_term u_term (
    .clk       (clk),
    .rst       (rst),
    .req       (treq),
    .term_done (term_done),
    .term      (term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_vertices <= '0;
      energy <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        num_vertices <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          n <= (num_vertices > VCOUNT_MAX) ? VCOUNT_MAX : num_vertices;
          i <= '0;
          acc <= '0;
          dsum <= '0;
          moved_cnt <= '0;
          if (accept) begin
            delta_mode <= (cmd == CMD_DELTA);
            unique case (cmd)
              CMD_FULL: state <= S_ROW_RD;
              CMD_DELTA: state <= S_MARK_RD;
              CMD_COMMIT: state <= S_COPY_RD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MARK_RD: begin
          if (i >= n) begin
            i <= '0;
            state <= S_ROW_RD;
          end else begin
            state <= S_MARK_CMP;
          end
        end
        S_MARK_CMP: begin
          moved_cnt <= moved_cnt + COUNT_W'(moved);
          i <= i + 1'b1;
          state <= S_MARK_RD;
        end
        S_ROW_RD: begin
          state <= (i >= n) ? S_DONE : S_ROW_LAT;
        end
        S_ROW_LAT: begin
          a_cur <= cur_rd;
          a_prev <= prev_rd;
          if (delta_mode && !mark_rd) begin
            i <= i + 1'b1;
            state <= S_ROW_RD;
          end else begin
            j <= delta_mode ? '0 : i + 1'b1;
            state <= S_COL_RD;
          end
        end
        S_COL_RD: begin
          if (j >= n) begin
            i <= i + 1'b1;
            state <= S_ROW_RD;
          end else begin
            state <= S_COL_LAT;
          end
        end
        S_COL_LAT: begin
          b_prev <= prev_rd;
          phase <= 1'b0;
          if (skip) begin
            j <= j + 1'b1;
            state <= S_COL_RD;
          end else begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          if (term_done) begin
            if (!phase && delta_mode) begin
              t_hold <= term;
              phase <= 1'b1;
            end else begin
              if (delta_mode) begin
                dsum <= dsum + $signed({{(ACC_W-TERM_W){1'b0}}, t_hold})
                             - $signed({{(ACC_W-TERM_W){1'b0}}, term});
              end else begin
                acc <= acc_sum[ENERGY_W] ? ENERGY_MAX : acc_sum[ENERGY_W-1:0];
              end
              j <= j + 1'b1;
              state <= S_COL_RD;
            end
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          if (i == VCOUNT_MAX - 1'b1) begin
            state <= S_IDLE;
          end else begin
            i <= i + 1'b1;
            state <= S_COPY_RD;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          if (delta_mode) begin
            if (e_sum < 0) begin
              energy <= '0;
              total_energy <= '0;
            end else if (e_sum > $signed({3'b000, ENERGY_MAX})) begin
              energy <= ENERGY_MAX;
              total_energy <= ENERGY_MAX;
            end else begin
              energy <= e_sum[ENERGY_W-1:0];
              total_energy <= e_sum[ENERGY_W-1:0];
            end
            energy_change <= dsum[ENERGY_W:0];
            moved_vertices <= moved_cnt;
          end else begin
            energy <= acc;
            total_energy <= acc;
            energy_change <= '0;
            moved_vertices <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_moved_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> moved_vertices <= n)
    else $error("moved count exceeds active vertex count");
  a_term_waited: assert property (@(posedge clk) disable iff (rst)
    term_done |-> state == S_TERM)
    else $error("pair term finished while sequencer was not waiting");
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !delta_mode) |-> (energy_change == '0 && moved_vertices == '0))
    else $error("full command reported a nonzero change");

endmodule

// File: hdl/pre_mem.sv
// Current and previous position stores and the moved marks, each a
// synchronous memory with one write and one registered read port. Uses pre_pkg.
module pre_mem (
  input  logic                      clk,
  input  pre_pkg::mem_req_t         req,
  output logic [pre_pkg::ENTRY_W-1:0] cur_rd,
  output logic [pre_pkg::ENTRY_W-1:0] prev_rd,
  output logic                      mark_rd
);
  import pre_pkg::*;

  logic [ENTRY_W-1:0] cur_mem [MAX_VERTICES];
  logic [ENTRY_W-1:0] prev_mem [MAX_VERTICES];
  logic               mark_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (req.cur_we) begin
      cur_mem[req.waddr] <= req.wdata;
    end
    if (req.prev_we) begin
      prev_mem[req.waddr] <= req.wdata;
    end
    if (req.mark_we) begin
      mark_mem[req.waddr] <= req.mark_wdata;
    end
    cur_rd <= cur_mem[req.raddr];
    prev_rd <= prev_mem[req.raddr];
    mark_rd <= mark_mem[req.raddr];
  end

endmodule

// File: hdl/pre_term.sv
// Pair term unit: squared distance, floor check and a bit-serial reciprocal
// divider producing floor(2^48 / d2) or the penalty. Uses pre_pkg.
module pre_term (
  input  logic                       clk,
  input  logic                       rst,
  input  pre_pkg::term_req_t         req,
  output logic                       term_done,
  output logic [pre_pkg::TERM_W-1:0] term
);
  import pre_pkg::*;

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_DIFF = 6'b000010,
    T_SQR  = 6'b000100,
    T_SUM  = 6'b001000,
    T_CHK  = 6'b010000,
    T_DIV  = 6'b100000
  } tstate_t;

  localparam int DIV_STEPS = 49;
  localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

  tstate_t state;
  logic [POS_W-1:0] ax, ay, bx, by;
  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [SQR_W-1:0] prod_x, prod_y;
  logic [SQR_W-1:0] sx, sy;
  logic [D2_W-1:0] d2;
  logic [D2_W-1:0] rem;
  logic [D2_W:0] rem_sh;
  logic [QUO_W-1:0] quo;
  logic [5:0] cnt;
  logic take;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign rem_sh = {rem, cnt == LAST_STEP};
  assign take = rem_sh >= {1'b0, d2};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      term_done <= 1'b0;
    end else begin
      term_done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            ax <= req.ax;
            ay <= req.ay;
            bx <= req.bx;
            by <= req.by;
            state <= T_DIFF;
          end
        end
        T_DIFF: begin
          dx <= $signed({ax[POS_W-1], ax}) - $signed({bx[POS_W-1], bx});
          dy <= $signed({ay[POS_W-1], ay}) - $signed({by[POS_W-1], by});
          state <= T_SQR;
        end
        T_SQR: begin
          sx <= $unsigned(prod_x);
          sy <= $unsigned(prod_y);
          state <= T_SUM;
        end
        T_SUM: begin
          d2 <= {1'b0, sx} + {1'b0, sy};
          state <= T_CHK;
        end
        T_CHK: begin
          if (d2 < DIST_FLOOR) begin
            term <= PENALTY;
            term_done <= 1'b1;
            state <= T_IDLE;
          end else begin
            rem <= '0;
            quo <= '0;
            cnt <= LAST_STEP;
            state <= T_DIV;
          end
        end
        T_DIV: begin
          if (take) begin
            rem <= D2_W'(rem_sh - {1'b0, d2});
          end else begin
            rem <= D2_W'(rem_sh);
          end
          quo <= {quo[QUO_W-2:0], take};
          if (cnt == '0) begin
            term <= TERM_W'({quo[QUO_W-2:0], take});
            term_done <= 1'b1;
            state <= T_IDLE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
